[src/dtrle_pkg.sv]
// ----------------------------------------------------------------------------
// dtrle_pkg
// Shared types and constants for the elevation tile run-length decoder.
// ----------------------------------------------------------------------------
package dtrle_pkg;

    localparam int WORD_W = 16;
    localparam int RAW_W  = 15;
    localparam int COLS_W = 7;
    localparam int ROWS_W = 13;
    localparam int COL_W  = 6;
    localparam int ROW_W  = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_ROWS = 2'd1;

    localparam logic [COLS_W-1:0] TILE_COLS_RST = 7'd64;
    localparam logic [ROWS_W-1:0] TILE_ROWS_RST = 13'd64;

    localparam logic [WORD_W-1:0] TILE_VERSION = 16'd2;
    localparam logic [RAW_W-1:0]  WATER_MARK   = 15'd10000;
    localparam logic [WORD_W-1:0] ELEV_OFFSET  = 16'd1000;

    typedef struct packed {
        logic signed [WORD_W-1:0] word;
        logic                     tile_start;
    } in_word_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] elevation;
        logic                     is_water;
        logic [COL_W-1:0]         column;
        logic [ROW_W-1:0]         row;
        logic                     last;
        logic                     header_bad;
    } out_word_t;

    typedef struct packed {
        logic clear_pos;
        logic emit_lit;
        logic load_run;
        logic emit_run;
        logic emit_bad;
    } dp_cmd_t;

    typedef struct packed {
        logic start;
        logic ver_ok;
        logic cols_ok;
        logic rows_ok;
        logic neg;
        logic run_empty;
        logic run_last;
        logic adv_done;
        logic out_free;
    } dp_status_t;

endpackage

[src/dem_tile_rle_decoder.sv]
// ----------------------------------------------------------------------------
// dem_tile_rle_decoder
// Run-length decoder for one elevation tile per start-marked header.
//
// Input channel s_*: one 16-bit signed stream word per transfer, tile_start
// marking the version word. Output channel m_*: one decoded sample word
// (elevation, water flag, column, row, last) or one header mismatch word.
// Configuration channel cfg_*: index 0 sets tile_cols, index 1 tile_rows;
// always ready; the user must write it while no word is in flight, as the block does not enforce this.
// A literal or header mismatch word is registered onto m_* as its input
// word is accepted. Words are accepted while the output register is free;
// a repeat word of n samples is taken, then they follow with s_ready low.
// The single output register and the run counter set this.
// Reset: phase idle, sizes 64 x 64, output register empty.
// When the receiver stalls, the output word holds and s_ready drops until
// the output register can take the next word.
// ----------------------------------------------------------------------------
module dem_tile_rle_decoder #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 4096
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dtrle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dtrle_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  dtrle_pkg::in_word_t              s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output dtrle_pkg::out_word_t             m_data
);
    import dtrle_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t st;

    dtrle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    dtrle_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .st        (st),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[src/dtrle_ctrl.sv]
// ----------------------------------------------------------------------------
// dtrle_ctrl
// Tile phase sequencer: header checks, body decode and run emission control.
// ----------------------------------------------------------------------------
module dtrle_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dtrle_pkg::dp_status_t st,
    output dtrle_pkg::dp_cmd_t    cmd
);
    import dtrle_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_HCOLS = 7'b0000010,
        ST_HROWS = 7'b0000100,
        ST_BODY  = 7'b0001000,
        ST_RUN   = 7'b0010000,
        ST_DONE  = 7'b0100000,
        ST_DROP  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   done_pend_reg, done_pend_next;
    logic   accept;

    assign s_ready = st.out_free && (state_reg != ST_RUN);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        done_pend_next = done_pend_reg;
        cmd            = '0;
        if (accept && st.start) begin
            cmd.clear_pos = 1'b1;
            if (st.ver_ok) begin
                state_next = ST_HCOLS;
            end else begin
                cmd.emit_bad = 1'b1;
                state_next   = ST_DROP;
            end
        end else begin
            case (state_reg)
                ST_HCOLS: begin
                    if (accept) begin
                        if (st.cols_ok) begin
                            state_next = ST_HROWS;
                        end else begin
                            cmd.emit_bad = 1'b1;
                            state_next   = ST_DROP;
                        end
                    end
                end
                ST_HROWS: begin
                    if (accept) begin
                        if (st.rows_ok) begin
                            state_next = ST_BODY;
                        end else begin
                            cmd.emit_bad = 1'b1;
                            state_next   = ST_DROP;
                        end
                    end
                end
                ST_BODY: begin
                    if (accept) begin
                        if (!st.neg) begin
                            cmd.emit_lit = 1'b1;
                            if (st.adv_done) begin
                                state_next = ST_DONE;
                            end
                        end else if (!st.run_empty) begin
                            cmd.load_run   = 1'b1;
                            done_pend_next = 1'b0;
                            state_next     = ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    if (st.out_free) begin
                        cmd.emit_run   = 1'b1;
                        done_pend_next = done_pend_reg || st.adv_done;
                        if (st.run_last) begin
                            state_next = (done_pend_reg || st.adv_done) ? ST_DONE : ST_BODY;
                        end
                    end
                end
                ST_IDLE, ST_DONE, ST_DROP: begin
                    state_next = state_reg;
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            done_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            done_pend_reg <= done_pend_next;
        end
    end

    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && st.out_free && st.run_last |=> state_reg != ST_RUN)
        else $error("run did not end on its last sample");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.emit_lit, cmd.load_run, cmd.emit_run, cmd.emit_bad}))
        else $error("conflicting datapath commands");

    a_bad_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_bad |=> state_reg == ST_DROP)
        else $error("header mismatch did not enter drop");

endmodule

[src/dtrle_dp.sv]
// ----------------------------------------------------------------------------
// dtrle_dp
// Decoder datapath: size registers, position counters, run counter, sample
// conversion and output register.
// ----------------------------------------------------------------------------
module dtrle_dp #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dtrle_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dtrle_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  dtrle_pkg::in_word_t                 s_data,
    input  dtrle_pkg::dp_cmd_t                  cmd,
    output dtrle_pkg::dp_status_t               st,
    output logic                                m_valid,
    input  logic                                m_ready,
    output dtrle_pkg::out_word_t                m_data
);
    import dtrle_pkg::*;

    logic [COLS_W-1:0] tile_cols_reg;
    logic [ROWS_W-1:0] tile_rows_reg;
    logic [RAW_W-1:0]  last_raw_reg, last_raw_next;
    logic [COLS_W-1:0] col_pos_reg, col_pos_next;
    logic [ROWS_W-1:0] row_pos_reg, row_pos_next;
    logic [WORD_W-1:0] run_rem_reg, run_rem_next;
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_data_reg, m_data_next;

    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] run_count;
    logic [COLS_W-1:0] room;
    logic [WORD_W-1:0] run_clip;
    logic [COLS_W:0]   col_inc;
    logic [ROWS_W:0]   row_inc;
    logic              row_wrap;
    logic [RAW_W-1:0]  raw_sel;
    logic              water;
    logic [RAW_W-1:0]  raw_adj;
    logic              emit;

    assign cfg_ready = 1'b1;
    assign w         = s_data.word;

    // run length is the magnitude of the negative word, clipped to the room left in the row
    assign run_count = 16'(17'h10000 - {1'b0, w});
    assign room      = tile_cols_reg - col_pos_reg;
    always_comb begin
        if (col_pos_reg > tile_cols_reg) begin
            run_clip = run_count;
        end else if (run_count > {9'd0, room}) begin
            run_clip = {9'd0, room};
        end else begin
            run_clip = run_count;
        end
    end

    assign col_inc  = {1'b0, col_pos_reg} + 8'd1;
    assign row_inc  = {1'b0, row_pos_reg} + 14'd1;
    assign row_wrap = col_inc >= {1'b0, tile_cols_reg};

    assign st.start     = s_data.tile_start;
    assign st.ver_ok    = w == TILE_VERSION;
    assign st.cols_ok   = (tile_cols_reg != '0) && (32'(tile_cols_reg) <= MAX_COLS)
                          && (w == {9'd0, tile_cols_reg});
    assign st.rows_ok   = (tile_rows_reg != '0) && (32'(tile_rows_reg) <= MAX_ROWS)
                          && (w == {3'd0, tile_rows_reg});
    assign st.neg       = w[WORD_W-1];
    assign st.run_empty = run_clip == '0;
    assign st.run_last  = run_rem_reg == 16'd1;
    assign st.adv_done  = row_wrap && (row_inc >= {1'b0, tile_rows_reg});
    assign st.out_free  = !m_valid_reg || m_ready;

    assign raw_sel = cmd.emit_lit ? w[RAW_W-1:0] : last_raw_reg;
    assign water   = raw_sel >= WATER_MARK;
    assign raw_adj = water ? raw_sel - WATER_MARK : raw_sel;
    assign emit    = cmd.emit_lit || cmd.emit_run;

    always_comb begin
        last_raw_next = last_raw_reg;
        col_pos_next  = col_pos_reg;
        row_pos_next  = row_pos_reg;
        run_rem_next  = run_rem_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        if (cmd.clear_pos) begin
            last_raw_next = '0;
            col_pos_next  = '0;
            row_pos_next  = '0;
        end
        if (cmd.load_run) begin
            run_rem_next = run_clip;
        end
        if (emit) begin
            m_valid_next          = 1'b1;
            m_data_next.elevation = {1'b0, raw_adj} - ELEV_OFFSET;
            m_data_next.is_water  = water;
            m_data_next.column    = col_pos_reg[COL_W-1:0];
            m_data_next.row       = row_pos_reg[ROW_W-1:0];
            m_data_next.last      = cmd.emit_lit || st.run_last;
            m_data_next.header_bad = 1'b0;
            if (cmd.emit_lit) begin
                last_raw_next = w[RAW_W-1:0];
            end
            if (cmd.emit_run) begin
                run_rem_next = run_rem_reg - 16'd1;
            end
            if (row_wrap) begin
                col_pos_next  = '0;
                last_raw_next = '0;
                row_pos_next  = row_inc[ROWS_W-1:0];
            end else begin
                col_pos_next = col_inc[COLS_W-1:0];
            end
        end
        if (cmd.emit_bad) begin
            m_valid_next           = 1'b1;
            m_data_next            = '0;
            m_data_next.last       = 1'b1;
            m_data_next.header_bad = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_cols_reg <= TILE_COLS_RST;
            tile_rows_reg <= TILE_ROWS_RST;
            last_raw_reg  <= '0;
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            run_rem_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_TILE_COLS) begin
                    tile_cols_reg <= cfg_data[COLS_W-1:0];
                end else if (cfg_index == CFG_TILE_ROWS) begin
                    tile_rows_reg <= cfg_data[ROWS_W-1:0];
                end
            end
            last_raw_reg <= last_raw_next;
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
            run_rem_reg  <= run_rem_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_bad_word: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_bad |=> m_valid_reg && m_data_reg.header_bad && m_data_reg.last)
        else $error("header mismatch word not presented");

    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_run |=> run_rem_reg != '0)
        else $error("empty run loaded");

    a_lit_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_lit |=> m_valid_reg && m_data_reg.last && !m_data_reg.header_bad)
        else $error("literal word not marked last");

endmodule
